// ===== rtl/bpa_pkg.sv =====
// Shared types and constants for the bitmap page allocator.
// No dependencies; every other file except bpa_ram refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

   localparam int FUNC_W   = 1;
   localparam int COUNT_W  = 17;
   localparam int ADDR_W   = 32;
   localparam int PAGE_W   = 16;
   localparam int STATUS_W = 1;
   localparam int TOTAL_W  = 17;
   localparam int WORD_W   = 32;
   localparam int CSR_AW   = 3;

   localparam logic [FUNC_W-1:0]   FUNC_ALLOC = 1'b0;
   localparam logic [FUNC_W-1:0]   FUNC_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 1'b0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 1'b1;

   // register index, taken from paddr[2]
   localparam logic REG_TOTAL_PAGES = 1'b0;

   localparam logic [TOTAL_W-1:0] TOTAL_PAGES_RESET = 17'h10000;

endpackage

`default_nettype wire

// ===== rtl/bpa_req_if.sv =====
// Request channel of the bitmap page allocator: valid/ready plus payload.
// Depends on bpa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bpa_req_if;
   logic                          valid;
   logic                          ready;
   logic [bpa_pkg::FUNC_W-1:0]    func;
   logic [bpa_pkg::COUNT_W-1:0]   page_count;
   logic [bpa_pkg::ADDR_W-1:0]    free_address;

   modport source (output valid, func, page_count, free_address, input ready);
   modport sink   (input valid, func, page_count, free_address, output ready);
endinterface

`default_nettype wire

// ===== rtl/bpa_rsp_if.sv =====
// Response channel of the bitmap page allocator: valid/ready plus payload.
// Depends on bpa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bpa_pkg::STATUS_W-1:0]  status;
   logic [bpa_pkg::PAGE_W-1:0]    base_page;
   logic [bpa_pkg::ADDR_W-1:0]    start_address;

   modport source (output valid, status, base_page, start_address, input ready);
   modport sink   (input valid, status, base_page, start_address, output ready);
endinterface

`default_nettype wire

// ===== rtl/bpa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/bitmap_page_allocator.sv =====
// Bitmap page allocator top level: next-fit search over a one-bit-per-page map.
// Depends on bpa_pkg, bpa_req_if, bpa_rsp_if and bpa_ram.
//
//   channel   dir  handshake          contents
//   req_ch    in   valid/ready        func, page_count, free_address
//   rsp_ch    out  valid/ready        status, base_page, start_address
//   csr       in   APB psel/penable   total_pages at byte address 0
//
// The map sits in one RAM of 32-bit words, each read in the state before its use.
// An allocate reads each word in S_RD, then scans one aligned octet of bits per
// cycle in S_SCAN (a fully free or fully used word needs a single check after its
// read), then marks the run by reading in S_MRD and writing in S_MWR; cost depends
// on where the free run lies, plus a second pass when the first fails.
// A free reads and writes each word touched in S_MRD and S_MWR before its response
// (none when nothing is cleared). One request is in flight at a time;
// a finished response waits in the output register while the next is accepted.
// After reset a clearing pass writes ceil(MAX_PAGES/32) words (2048 by default)
// with all ones; requests are held off during that pass.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator #(
   parameter int MAX_PAGES  = 65536,
   parameter int PAGE_BYTES = 4096   // power of two
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   bpa_req_if.sink                          req_ch,
   bpa_rsp_if.source                        rsp_ch,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [bpa_pkg::CSR_AW-1:0]  paddr,
   input  wire logic [31:0]                 pwdata,
   output logic      [31:0]                 prdata,
   output logic                             pready
);

   localparam int PW0        = $clog2(MAX_PAGES + 1);
   localparam int PW         = (PW0 > 6) ? PW0 : 6;
   localparam int WORDS      = (MAX_PAGES + 31) / 32;
   localparam int WAW        = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int CW         = bpa_pkg::COUNT_W;

   typedef enum logic [6:0] {
      S_CLR  = 7'b0000001,
      S_IDLE = 7'b0000010,
      S_RD   = 7'b0000100,
      S_SCAN = 7'b0001000,
      S_MRD  = 7'b0010000,
      S_MWR  = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [bpa_pkg::TOTAL_W-1:0] total_pages_ff, total_pages_in;
   logic [PW-1:0]  cursor_ff, cursor_in;
   logic [PW-1:0]  pos_ff, pos_in;
   logic [PW-1:0]  start_ff, start_in;
   logic [CW-1:0]  run_ff, run_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           pass_ff, pass_in;
   logic           mark_set_ff, mark_set_in;
   logic [PW-1:0]  lo_ff, lo_in;
   logic [PW-1:0]  hi_ff, hi_in;
   logic [WAW-1:0] wptr_ff, wptr_in;
   logic [bpa_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [PW-1:0]  res_first_ff, res_first_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [bpa_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic [bpa_pkg::PAGE_W-1:0]   out_first_ff, out_first_in;
   logic [bpa_pkg::ADDR_W-1:0]   out_addr_ff, out_addr_in;

   logic                         ram_we, ram_re;
   logic [WAW-1:0]               ram_raddr;
   logic [bpa_pkg::WORD_W-1:0]   ram_wdata, rd_word, mask;
   logic [PW-1:0]                lim;
   logic                         req_fire, rsp_fire, csr_wr;

   // scan step results
   logic [PW-1:0]  q, sc_start, sc_fpos, base;
   logic [CW-1:0]  sc_run;
   logic           sc_hit, sc_fail, fast_free, fast_used;
   logic [CW:0]    run_plus_word;
   logic [PW:0]    base_end;

   // free range
   logic [33:0]    fr_lo, fr_hi, fr_hic;
   logic [31:0]    mb;
   logic [WAW-1:0] whi;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;
   assign csr_wr   = psel && penable && pwrite && pready;

   assign lim = ({15'd0, total_pages_ff} > 32'(MAX_PAGES)) ? PW'(MAX_PAGES)
                                                         : PW'(total_pages_ff);

   assign pready = 1'b1;
   assign prdata = (paddr[2] == bpa_pkg::REG_TOTAL_PAGES) ? 32'(total_pages_ff) : 32'd0;

   assign req_ch.ready         = (state_ff == S_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = out_status_ff;
   assign rsp_ch.base_page     = out_first_ff;
   assign rsp_ch.start_address = out_addr_ff;

   bpa_ram #(
      .WIDTH (bpa_pkg::WORD_W),
      .DEPTH (WORDS),
      .ADDR_W(WAW)
   ) u_map (
      .clock(clock),
      .we   (ram_we),
      .waddr(wptr_ff),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(rd_word)
   );

   // one aligned octet of the scan, bit by bit
   always_comb begin
      sc_run   = run_ff;
      sc_start = start_ff;
      sc_hit   = 1'b0;
      sc_fail  = 1'b0;
      sc_fpos  = pos_ff;
      q        = pos_ff;
      for (int j = 0; j < 8; j++) begin
         q = {pos_ff[PW-1:3], 3'(j)};
         if (!sc_hit && !sc_fail && (3'(j) >= pos_ff[2:0])) begin
            if (q >= lim) begin
               sc_fail = 1'b1;
               sc_fpos = q;
            end else if (!rd_word[q[4:0]]) begin
               sc_run = sc_run + CW'(1);
               if (sc_run == count_ff) begin
                  sc_hit = 1'b1;
               end
            end else begin
               sc_start = q + PW'(1);
               sc_run   = '0;
            end
         end
      end
   end

   // whole-word shortcuts at a word boundary
   assign base          = {pos_ff[PW-1:5], 5'd0};
   assign base_end      = {1'b0, base} + (PW+1)'(32);
   assign run_plus_word = {1'b0, run_ff} + (CW+1)'(32);
   assign fast_free = (pos_ff[4:0] == 5'd0) && (rd_word == '0) &&
                      (base_end <= {1'b0, lim}) && (run_plus_word < {1'b0, count_ff});
   assign fast_used = (pos_ff[4:0] == 5'd0) && (rd_word == '1) &&
                      (base_end <= {1'b0, lim});

   // set or clear mask for the word under wptr
   always_comb begin
      mask = '0;
      mb   = '0;
      for (int j = 0; j < 32; j++) begin
         mb      = 32'({wptr_ff, 5'd0}) + 32'(j);
         mask[j] = (mb >= 32'(lo_ff)) && (mb < 32'(hi_ff));
      end
   end

   assign whi       = WAW'((hi_ff - PW'(1)) >> 5);
   assign ram_wdata = (state_ff == S_CLR) ? '1
                    : (mark_set_ff ? (rd_word | mask) : (rd_word & ~mask));

   assign fr_lo  = 34'(req_ch.free_address >> PAGE_SHIFT);
   assign fr_hi  = fr_lo + 34'(req_ch.page_count);
   assign fr_hic = (fr_hi > 34'(MAX_PAGES)) ? 34'(MAX_PAGES) : fr_hi;

   always_comb begin
      state_in       = state_ff;
      total_pages_in = total_pages_ff;
      cursor_in      = cursor_ff;
      pos_in         = pos_ff;
      start_in       = start_ff;
      run_in         = run_ff;
      count_in       = count_ff;
      pass_in        = pass_ff;
      mark_set_in    = mark_set_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      wptr_in        = wptr_ff;
      res_status_in  = res_status_ff;
      res_first_in   = res_first_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_fire;
      out_status_in  = out_status_ff;
      out_first_in   = out_first_ff;
      out_addr_in    = out_addr_ff;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      ram_raddr      = wptr_ff;

      if (csr_wr && (paddr[2] == bpa_pkg::REG_TOTAL_PAGES)) begin
         total_pages_in = pwdata[bpa_pkg::TOTAL_W-1:0];
      end

      unique case (state_ff)
         S_CLR: begin
            ram_we  = 1'b1;
            wptr_in = wptr_ff + WAW'(1);
            if (wptr_ff == WAW'(WORDS - 1)) begin
               wptr_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               count_in = req_ch.page_count;
               if (req_ch.func == bpa_pkg::FUNC_FREE) begin
                  mark_set_in   = 1'b0;
                  res_status_in = bpa_pkg::STATUS_OK;
                  res_first_in  = '0;
                  lo_in         = PW'(fr_lo);
                  hi_in         = PW'(fr_hic);
                  wptr_in       = WAW'(fr_lo >> 5);
                  state_in      = (fr_lo >= fr_hic) ? S_DONE : S_MRD;
               end else if (req_ch.page_count == '0) begin
                  mark_set_in   = 1'b0;
                  cursor_in     = '0;
                  res_status_in = bpa_pkg::STATUS_FULL;
                  res_first_in  = '0;
                  state_in      = S_DONE;
               end else begin
                  mark_set_in = 1'b1;
                  pass_in     = 1'b0;
                  pos_in      = cursor_ff;
                  start_in    = cursor_ff;
                  run_in      = '0;
                  state_in    = S_RD;
               end
            end
         end
         S_RD: begin
            ram_re    = 1'b1;
            ram_raddr = WAW'(pos_ff >> 5);
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            if (fast_free) begin
               run_in   = run_plus_word[CW-1:0];
               pos_in   = base_end[PW-1:0];
               state_in = S_RD;
            end else if (fast_used) begin
               start_in = base_end[PW-1:0];
               run_in   = '0;
               pos_in   = base_end[PW-1:0];
               state_in = S_RD;
            end else if (sc_hit) begin
               // run found: mark it, cursor goes just past it
               res_first_in = sc_start;
               lo_in        = sc_start;
               hi_in        = sc_start + PW'(count_ff);
               cursor_in    = sc_start + PW'(count_ff);
               wptr_in      = WAW'(sc_start >> 5);
               state_in     = S_MRD;
            end else if (sc_fail) begin
               if (!pass_ff) begin
                  cursor_in = '0;
                  pass_in   = 1'b1;
                  pos_in    = '0;
                  start_in  = '0;
                  run_in    = '0;
                  state_in  = S_RD;
               end else begin
                  cursor_in     = sc_fpos;
                  res_status_in = bpa_pkg::STATUS_FULL;
                  res_first_in  = '0;
                  state_in      = S_DONE;
               end
            end else begin
               run_in   = sc_run;
               start_in = sc_start;
               pos_in   = {pos_ff[PW-1:3] + (PW-3)'(1), 3'd0};
               state_in = (pos_ff[4:3] == 2'b11) ? S_RD : S_SCAN;
            end
         end
         S_MRD: begin
            ram_re   = 1'b1;
            state_in = S_MWR;
         end
         S_MWR: begin
            ram_we = 1'b1;
            if (wptr_ff == whi) begin
               if (!mark_set_ff) begin
                  state_in = S_DONE;
               end else if (res_first_ff != '0) begin
                  res_status_in = bpa_pkg::STATUS_OK;
                  state_in      = S_DONE;
               end else if (!pass_ff) begin
                  // run at page zero counts as failure: retry from zero
                  cursor_in = '0;
                  pass_in   = 1'b1;
                  pos_in    = '0;
                  start_in  = '0;
                  run_in    = '0;
                  state_in  = S_RD;
               end else begin
                  res_status_in = bpa_pkg::STATUS_FULL;
                  state_in      = S_DONE;
               end
            end else begin
               // read the next word while this one is written
               wptr_in   = wptr_ff + WAW'(1);
               ram_re    = 1'b1;
               ram_raddr = wptr_ff + WAW'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_first_in  = bpa_pkg::PAGE_W'(res_first_ff);
               out_addr_in   = 32'(64'(res_first_ff) << PAGE_SHIFT);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLR;
         total_pages_ff <= bpa_pkg::TOTAL_PAGES_RESET;
         cursor_ff      <= '0;
         pass_ff        <= 1'b0;
         mark_set_ff    <= 1'b0;
         wptr_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         total_pages_ff <= total_pages_in;
         cursor_ff      <= cursor_in;
         pass_ff        <= pass_in;
         mark_set_ff    <= mark_set_in;
         wptr_ff        <= wptr_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      start_ff      <= start_in;
      run_ff        <= run_in;
      count_ff      <= count_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      res_status_ff <= res_status_in;
      res_first_ff  <= res_first_in;
      out_status_ff <= out_status_in;
      out_first_ff  <= out_first_in;
      out_addr_ff   <= out_addr_in;
   end

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= PW'(MAX_PAGES))
      else $error("search cursor beyond the map");

   a_run_short: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (run_ff < count_ff))
      else $error("scan holds a complete run without stopping");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("accepted transaction did not start");

   a_success_nonzero: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && mark_set_ff && (res_status_ff == bpa_pkg::STATUS_OK))
      |-> (res_first_ff != '0))
      else $error("successful allocation at page zero");

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == S_CLR) || (state_ff == S_MWR)))
      else $error("map written outside clear or mark phase");

endmodule

`default_nettype wire
